// ----- hw/rtl/stb_pkg.sv -----
// stb_pkg: shared types and constants for the soft timer bank
// holds the command and result words, the timer entry layout and the kind codes
// no dependencies
package stb_pkg;

  // bank size and counter width
  localparam int NUM_TIMERS  = 5;
  localparam int COUNT_WIDTH = 32;

  // address width into the timer store
  localparam int TIMER_AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  // field widths of the stream words
  localparam int KIND_W   = 3;
  localparam int IDX_W    = 4;
  localparam int RELOAD_W = 32;
  localparam int MASK_W   = 16;

  // command kinds carried in tuser
  typedef enum logic [KIND_W-1:0] {
    KIND_TICK    = 3'd0,
    KIND_START   = 3'd1,
    KIND_STOP    = 3'd2,
    KIND_RELOAD  = 3'd3,
    KIND_SETFLAG = 3'd4,
    KIND_READ    = 3'd5
  } kind_e;

  // one accepted input word
  typedef struct packed {
    kind_e                kind;
    logic [IDX_W-1:0]     timer_index;
    logic [RELOAD_W-1:0]  reload_value;
    logic                 flag_value;
    logic                 clear_on_read;
  } cmd_t;

  // one result word
  typedef struct packed {
    logic              flag_out;
    logic [MASK_W-1:0] expired_mask;
  } res_t;

  // one timer entry in the store
  typedef struct packed {
    logic                   en;
    logic                   flag;
    logic [COUNT_WIDTH-1:0] down;
    logic [COUNT_WIDTH-1:0] reload;
  } entry_t;

endpackage

// ----- hw/rtl/stb_ram.sv -----
// stb_ram: generic single-write, single-read synchronous ram
// read data is registered
// no dependencies
module stb_ram #(
  parameter int DEPTH = 5,
  parameter int WIDTH = 66
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/stb_engine.sv -----
// stb_engine: read-modify-write sequencer over the timer store
// walks every entry on a tick, touches one entry on an in-range command
// depends on stb_pkg and stb_ram
module stb_engine
  import stb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cmd_t              in_cmd_i,
  input  logic [MASK_W-1:0] periodic_mask_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output res_t              res_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DONE
  } state_e;

  localparam logic [TIMER_AW-1:0] LAST_TIMER = TIMER_AW'(NUM_TIMERS - 1);

  state_e                 state_q, state_d;
  cmd_t                   cmd_q, cmd_d;
  logic [TIMER_AW-1:0]    cur_q, cur_d;
  logic [NUM_TIMERS-1:0]  exp_q, exp_d;
  res_t                   res_q, res_d;
  logic [NUM_TIMERS-1:0]  valid_q;
  logic [NUM_TIMERS-1:0]  pmask;

  logic                   ram_we, ram_re;
  logic [TIMER_AW-1:0]    ram_raddr;
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t                 cur_entry, wentry;
  logic [COUNT_WIDTH-1:0] dec;
  logic                   idx_ok;

  assign pmask = periodic_mask_i[NUM_TIMERS-1:0];

  // timer store
  stb_ram #(
    .DEPTH(NUM_TIMERS),
    .WIDTH($bits(entry_t))
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(cur_q),
    .wdata_i(wentry),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // entry never written reads as the reset value
  assign cur_entry = valid_q[cur_q] ? entry_t'(ram_rdata) : '0;
  assign dec       = cur_entry.down - COUNT_WIDTH'(1);
  assign idx_ok    = ({1'b0, in_cmd_i.timer_index} < (IDX_W + 1)'(NUM_TIMERS));

  // sequencer next state and entry update
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    cur_d       = cur_q;
    exp_d       = exp_q;
    res_d       = res_q;
    ram_re      = 1'b0;
    ram_raddr   = cur_q;
    ram_we      = 1'b0;
    wentry      = cur_entry;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_d = in_cmd_i;
          exp_d = '0;
          res_d = '0;
          if (in_cmd_i.kind == KIND_TICK) begin
            cur_d     = '0;
            ram_re    = 1'b1;
            ram_raddr = '0;
            state_d   = ST_READ;
          end else if (idx_ok && (in_cmd_i.kind inside {KIND_START, KIND_STOP,
                       KIND_RELOAD, KIND_SETFLAG, KIND_READ})) begin
            cur_d     = in_cmd_i.timer_index[TIMER_AW-1:0];
            ram_re    = 1'b1;
            ram_raddr = in_cmd_i.timer_index[TIMER_AW-1:0];
            state_d   = ST_READ;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_READ: begin
        ram_we  = 1'b1;
        state_d = ST_DONE;
        case (cmd_q.kind)
          KIND_TICK: begin
            // count down, fire and maybe reload
            if (cur_entry.en && (cur_entry.down != '0)) begin
              wentry.down = dec;
              if (dec == '0) begin
                wentry.flag  = 1'b1;
                exp_d[cur_q] = 1'b1;
                if (pmask[cur_q]) begin
                  wentry.down = cur_entry.reload;
                end
              end
            end
            if (cur_q == LAST_TIMER) begin
              res_d.expired_mask = MASK_W'(exp_d);
            end else begin
              // next entry read overlaps this write, different address
              cur_d     = cur_q + 1'b1;
              ram_re    = 1'b1;
              ram_raddr = cur_q + 1'b1;
              state_d   = ST_READ;
            end
          end
          KIND_START: begin
            wentry.flag = 1'b0;
            wentry.down = cur_entry.reload;
            wentry.en   = 1'b1;
          end
          KIND_STOP: begin
            wentry.en = 1'b0;
          end
          KIND_RELOAD: begin
            wentry.reload = cmd_q.reload_value[COUNT_WIDTH-1:0];
          end
          KIND_SETFLAG: begin
            wentry.flag = cmd_q.flag_value;
          end
          KIND_READ: begin
            res_d.flag_out = cur_entry.flag;
            if (cmd_q.clear_on_read) begin
              wentry.flag = 1'b0;
            end
          end
          default: begin
            ram_we = 1'b0;
          end
        endcase
      end
      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cur_q   <= '0;
      exp_q   <= '0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      exp_q   <= exp_d;
      res_q   <= res_d;
    end
  end

  // command payload
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  // per-entry written marks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ram_we) begin
      valid_q[cur_q] <= 1'b1;
    end
  end

  assign res_o = res_q;

  // store is only written while an entry is being processed
  a_we_only_in_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_READ) |-> !ram_we)
    else $error("store written outside read-modify-write");

  // a tick walk advances one entry per cycle
  a_tick_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ && cmd_q.kind == KIND_TICK && cur_q != LAST_TIMER)
    |=> (state_q == ST_READ && cur_q == $past(cur_q) + 1'b1))
    else $error("tick walk skipped or stalled");

  // only a tick reports expiries
  a_mask_only_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && cmd_q.kind != KIND_TICK) |-> (res_o.expired_mask == '0))
    else $error("expired mask on a non-tick word");

  // only a read returns a flag
  a_flag_only_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && cmd_q.kind != KIND_READ) |-> !res_o.flag_out)
    else $error("flag returned on a non-read word");

endmodule

// ----- hw/rtl/soft_timer_bank_top.sv -----
// soft_timer_bank_top: bank of down-counting timers on stream channels
// slave side takes tick and command words, master side returns one word each
// depends on stb_pkg and stb_engine
//
// usage:
//   s_axis carries one word per tick or command; the kind sits in tuser.
//   m_axis returns exactly one word per accepted input word, in order.
//   cfg_we_i writes periodic_mask (bit per timer: reload after expiry).
// tick and command flow:
//   a tick walks all NUM_TIMERS entries of the timer ram, one entry per
//   cycle, set by the single read and write port of that ram; its result
//   is registered in the engine, then in the output register before m_axis,
//   and the next word is taken only once that result has left the engine.
//   a command reads, modifies and writes back one entry.
//   out-of-range indexes and unused kinds skip the ram.
// reset:
//   all timers disabled, counters, reloads and flags zero, periodic_mask 15.
// stall:
//   one result waits in the output register while the next word is worked
//   on; that word then holds until the register frees, and s_axis_tready
//   stays low meanwhile.
module soft_timer_bank_top
  import stb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // slave side
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // timer_index[3:0], reload_value[35:4], flag_value[36], clear_on_read[37]
  input  logic [39:0]        s_axis_tdata,
  // kind[2:0]
  input  logic [KIND_W-1:0]  s_axis_tuser,
  // master side
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // flag_out[0], expired_mask[16:1]
  output logic [23:0]        m_axis_tdata,
  // configuration
  input  logic               cfg_we_i,
  input  logic [MASK_W-1:0]  cfg_wdata_i
);

  logic [MASK_W-1:0] periodic_mask_q;
  cmd_t              in_cmd;
  res_t              eng_res;
  logic              eng_res_valid, eng_res_ready;
  logic              out_valid_q;
  res_t              out_data_q;

  // periodic mask register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      periodic_mask_q <= MASK_W'(15);
    end else if (cfg_we_i) begin
      periodic_mask_q <= cfg_wdata_i;
    end
  end

  // unpack input word
  assign in_cmd.kind          = kind_e'(s_axis_tuser);
  assign in_cmd.timer_index   = s_axis_tdata[3:0];
  assign in_cmd.reload_value  = s_axis_tdata[35:4];
  assign in_cmd.flag_value    = s_axis_tdata[36];
  assign in_cmd.clear_on_read = s_axis_tdata[37];

  stb_engine u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_cmd_i       (in_cmd),
    .periodic_mask_i(periodic_mask_q),
    .res_valid_o    (eng_res_valid),
    .res_ready_i    (eng_res_ready),
    .res_o          (eng_res)
  );

  // output register
  assign eng_res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (eng_res_ready) begin
      out_valid_q <= eng_res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eng_res_valid && eng_res_ready) begin
      out_data_q <= eng_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_data_q.expired_mask, out_data_q.flag_out};

endmodule
